[rtl/nnbt_pkg.sv]
// shared types and codes for the nearest neighbour blob tracker
package nnbt_pkg;

  typedef struct packed {
    logic        valid;
    logic        touched;
    logic [3:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } slot_t;

  typedef struct packed {
    logic rotate;
    logic pack;
    logic phase;
  } cell_ctrl_t;

  localparam logic [1:0] EV_ENTERED = 2'd0;
  localparam logic [1:0] EV_MOVED   = 2'd1;
  localparam logic [1:0] EV_EXITED  = 2'd2;
  localparam logic [1:0] EV_DONE    = 2'd3;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_EOF   = 1'b1;

  // 13107 squared
  localparam logic [31:0] R2_RESET = 32'd171793449;

endpackage

[rtl/nnbt_cell.sv]
// one slot of the tracker ring: rotates toward the head or packs with a neighbor
module nnbt_cell import nnbt_pkg::*; #(
  parameter int IDX        = 0,
  parameter int SLOT_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  slot_t      from_next,
  input  slot_t      from_prev,
  output slot_t      q
);

  localparam logic PARITY = IDX % 2 == 1;

  slot_t slot_r, slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.rotate) begin
      slot_nxt = from_next;
    end else if (ctrl.pack) begin
      if (PARITY == ctrl.phase) begin
        // left member of a pair: pull a live slot over a hole
        if (IDX < SLOT_COUNT - 1 && !slot_r.valid && from_next.valid) begin
          slot_nxt = from_next;
        end
      end else begin
        if (IDX > 0 && !from_prev.valid && slot_r.valid) begin
          slot_nxt = from_prev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid   <= 1'b0;
      slot_r.touched <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;

endmodule

[rtl/nearest_neighbour_blob_tracker.sv]
// top level of the nearest neighbour blob tracker: sequencer, ring of slot cells, output word
//
//  channel | ports                                      | handshake
//  in      | in_command in_pos_x in_pos_y in_pos_z      | in_valid / in_stall
//  out     | out_event_kind out_blob_id out_x/y/z last  | out_valid / out_stall
//  cfg     | cfg_data (match radius)                    | cfg_we
//
// a point runs one ring rotation to find the nearest
// blob, a decide step, then one rotation to write the slot back
// end of frame runs a rotation emitting exits, then an
// odd-even packing sweep, then the done word
// a word waiting on out_stall holds the decide step, every cycle of the exit
// rotation and the done step
// reset clears the slot valid and touched bits at once, no clearing pass
module nearest_neighbour_blob_tracker import nnbt_pkg::*; #(
  parameter int MAX_BLOBS  = 16,
  parameter int SLOT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_pos_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [3:0]  out_blob_id,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_z,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int KW    = $clog2(SLOT_COUNT);
  localparam int LW    = $clog2(SLOT_COUNT + 1);
  localparam int PW    = $clog2(MAX_BLOBS + 1);
  localparam int LIMIT = MAX_BLOBS < 16 ? MAX_BLOBS : 16;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_EXIT   = 3'd4;
  localparam logic [2:0] S_PACK   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // ring of slot cells, head is cell 0, write-back enters at the tail
  slot_t      q [SLOT_COUNT];
  slot_t      head, wb;
  cell_ctrl_t ctrl;

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [LW-1:0] live_r, live_nxt;
  logic [PW-1:0] ptf_r, ptf_nxt;
  logic [15:0]   px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic          found_r, found_nxt;
  logic [KW-1:0] best_k_r, best_k_nxt;
  logic [32:0]   best_d2_r, best_d2_nxt;
  logic [31:0]   best_dz2_r, best_dz2_nxt;
  logic [3:0]    best_id_r, best_id_nxt;
  logic [15:0]   used_r, used_nxt;
  logic          match_r, match_nxt;
  logic [3:0]    newid_r, newid_nxt;
  logic [31:0]   r2_r, r2_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  id_r, id_nxt;
  logic [15:0] ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic        last_r, last_nxt;

  logic        adv, load, k_last, match_now;
  logic [15:0] dx, dy, dz;
  logic [32:0] d2;
  logic [31:0] dz2;
  logic [33:0] d3;
  logic [3:0]  newid;

  genvar gi;
  generate
    for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      slot_t nb_next, nb_prev;
      if (gi == SLOT_COUNT - 1) begin : g_tail
        assign nb_next = wb;
      end else begin : g_mid
        assign nb_next = q[gi+1];
      end
      if (gi == 0) begin : g_head
        assign nb_prev = q[0];
      end else begin : g_rest
        assign nb_prev = q[gi-1];
      end
      nnbt_cell #(.IDX(gi), .SLOT_COUNT(SLOT_COUNT)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
        .from_next(nb_next), .from_prev(nb_prev), .q(q[gi])
      );
    end
  endgenerate

  assign head   = q[0];
  assign adv    = !out_valid_r || !out_stall;
  assign k_last = k_r == KW'(SLOT_COUNT - 1);

  // distance of the point to the slot at the head
  always_comb begin
    dx  = head.x > px_r ? head.x - px_r : px_r - head.x;
    dy  = head.y > py_r ? head.y - py_r : py_r - head.y;
    dz  = head.z > pz_r ? head.z - pz_r : pz_r - head.z;
    d2  = {1'b0, 32'(dx * dx)} + {1'b0, 32'(dy * dy)};
    dz2 = 32'(dz * dz);
    d3  = {1'b0, best_d2_r} + {2'b0, best_dz2_r};
    match_now = found_r && d3 <= {2'b0, r2_r};
  end

  // lowest id not held by a live blob, 0 when all are taken
  always_comb begin
    newid = 4'd0;
    for (int j = LIMIT - 1; j >= 0; j--) begin
      if (!used_r[j]) newid = 4'(j);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    live_nxt     = live_r;
    ptf_nxt      = ptf_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pz_nxt       = pz_r;
    found_nxt    = found_r;
    best_k_nxt   = best_k_r;
    best_d2_nxt  = best_d2_r;
    best_dz2_nxt = best_dz2_r;
    best_id_nxt  = best_id_r;
    used_nxt     = used_r;
    match_nxt    = match_r;
    newid_nxt    = newid_r;
    r2_nxt       = cfg_we ? 32'(cfg_data * cfg_data) : r2_r;
    wb           = head;
    ctrl         = '0;
    ctrl.phase   = k_r[0];
    load         = 1'b0;
    kind_nxt     = kind_r;
    id_nxt       = id_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    oz_nxt       = oz_r;
    last_nxt     = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt = '0;
          if (in_command == CMD_EOF) begin
            state_nxt = S_EXIT;
          end else if (ptf_r < PW'(MAX_BLOBS)) begin
            ptf_nxt   = ptf_r + PW'(1);
            px_nxt    = in_pos_x;
            py_nxt    = in_pos_y;
            pz_nxt    = in_pos_z;
            found_nxt = 1'b0;
            used_nxt  = '0;
            live_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.rotate = 1'b1;
        k_nxt = k_r + KW'(1);
        if (head.valid) begin
          live_nxt          = live_r + LW'(1);
          used_nxt[head.id] = 1'b1;
          // strict compare keeps the earliest slot on a tie
          if (!found_r || d2 < best_d2_r) begin
            found_nxt    = 1'b1;
            best_k_nxt   = k_r;
            best_d2_nxt  = d2;
            best_dz2_nxt = dz2;
            best_id_nxt  = head.id;
          end
        end
        if (k_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (adv) begin
          match_nxt = match_now;
          newid_nxt = newid;
          k_nxt     = '0;
          ox_nxt    = px_r;
          oy_nxt    = py_r;
          oz_nxt    = pz_r;
          last_nxt  = 1'b1;
          if (match_now) begin
            load      = 1'b1;
            kind_nxt  = EV_MOVED;
            id_nxt    = best_id_r;
            state_nxt = S_UPD;
          end else if (live_r == LW'(SLOT_COUNT)) begin
            // no free slot: the point is dropped
            state_nxt = S_IDLE;
          end else begin
            load      = 1'b1;
            kind_nxt  = EV_ENTERED;
            id_nxt    = newid;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        ctrl.rotate = 1'b1;
        k_nxt = k_r + KW'(1);
        if (match_r && k_r == best_k_r) begin
          wb.x       = px_r;
          wb.y       = py_r;
          wb.z       = pz_r;
          wb.touched = 1'b1;
        end else if (!match_r && LW'(k_r) == live_r) begin
          wb.valid   = 1'b1;
          wb.touched = 1'b1;
          wb.id      = newid_r;
          wb.x       = px_r;
          wb.y       = py_r;
          wb.z       = pz_r;
        end
        if (k_last) state_nxt = S_IDLE;
      end
      S_EXIT: begin
        if (adv) begin
          ctrl.rotate = 1'b1;
          k_nxt = k_r + KW'(1);
          if (head.valid && !head.touched) begin
            load       = 1'b1;
            kind_nxt   = EV_EXITED;
            id_nxt     = head.id;
            ox_nxt     = head.x;
            oy_nxt     = head.y;
            oz_nxt     = head.z;
            last_nxt   = 1'b0;
            wb.valid   = 1'b0;
            wb.touched = 1'b0;
          end else begin
            wb.touched = 1'b0;
          end
          if (k_last) state_nxt = S_PACK;
        end
      end
      S_PACK: begin
        // odd-even sweep moves live slots down over holes, order kept
        ctrl.pack = 1'b1;
        k_nxt = k_r + KW'(1);
        if (k_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (adv) begin
          load      = 1'b1;
          kind_nxt  = EV_DONE;
          id_nxt    = 4'd0;
          ox_nxt    = 16'd0;
          oy_nxt    = 16'd0;
          oz_nxt    = 16'd0;
          last_nxt  = 1'b1;
          ptf_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    live_r     <= live_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    best_k_r   <= best_k_nxt;
    best_d2_r  <= best_d2_nxt;
    best_dz2_r <= best_dz2_nxt;
    best_id_r  <= best_id_nxt;
    used_r     <= used_nxt;
    match_r    <= match_nxt;
    newid_r    <= newid_nxt;
    found_r    <= found_nxt;
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    oz_r       <= oz_nxt;
    last_r     <= last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptf_r       <= '0;
      r2_r        <= R2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptf_r       <= ptf_nxt;
      r2_r        <= r2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall       = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_blob_id    = id_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_z          = oz_r;
  assign out_last       = last_r;

  logic [SLOT_COUNT-1:0] vv;
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) vv[i] = q[i].valid;
  end

  // live slots stay packed at the low end between words
  generate
    for (gi = 1; gi < SLOT_COUNT; gi++) begin : g_chk
      a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_r == S_IDLE && vv[gi]) |-> vv[gi-1])
        else $error("slot ring has a hole below a live slot");
    end
  endgenerate

  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |-> live_r == LW'($countones(vv)))
    else $error("live count disagrees with ring");

  a_ptf: assert property (@(posedge clk) disable iff (!rst_n)
    ptf_r <= PW'(MAX_BLOBS))
    else $error("point count past per-frame limit");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == EV_DONE) |-> (last_r && id_r == 4'd0))
    else $error("done word malformed");

endmodule

[tb/nearest_neighbour_blob_tracker_tb.sv]
// testbench for the nearest neighbour blob tracker: directed table, random frames, predicted events
`timescale 1ns / 100ps

module nearest_neighbour_blob_tracker_tb import nnbt_pkg::*;;

  localparam int MAXB  = 16;
  localparam int SLOTS = 32;
  localparam int LIMIT = 2000000;
  localparam int TAIL  = 4 * SLOTS + 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
  } event_word_t;

  // directed row: input word, optional typed expectation
  typedef struct {
    logic        cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    bit          typed;
    event_word_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_POINT;
  logic [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [3:0]  out_blob_id;
  logic [15:0] out_x, out_y, out_z;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  always #4 clk = ~clk;

  nearest_neighbour_blob_tracker uut (.*);

  // tracker image for prediction
  logic [15:0] radius;
  bit          t_valid[SLOTS];
  bit          t_touched[SLOTS];
  logic [3:0]  t_id[SLOTS];
  logic [15:0] t_pos[SLOTS][3];
  int          live, frame_points;

  event_word_t expected_events[$];
  bit          typed_pending[$];
  event_word_t typed_want[$];
  int          queued_total = 0;
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 9, recv_idle = 87;

  function automatic longint unsigned sqd(logic [15:0] a, logic [15:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic logic [3:0] free_id();
    bit used;
    for (int id = 0; id < MAXB && id < 16; id++) begin
      used = 0;
      for (int i = 0; i < live; i++) if (t_valid[i] && t_id[i] == id) used = 1;
      if (!used) return id[3:0];
    end
    return 4'd0;
  endfunction

  function automatic event_word_t ev(logic [1:0] k, logic [3:0] id, logic [15:0] x,
                                     logic [15:0] y, logic [15:0] z, logic l);
    event_word_t e;
    e.kind = k; e.id = id; e.x = x; e.y = y; e.z = z; e.last = l;
    return e;
  endfunction

  // append a predicted word and count it
  task automatic queue_event(event_word_t e);
    expected_events.insert(expected_events.size(), e);
    queued_total++;
  endtask

  // advance the image by one input word and queue the events it causes
  task automatic track_word(logic cmd, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    bit found;
    int best, w;
    longint unsigned d, best_d;
    if (cmd == CMD_POINT) begin
      if (frame_points >= MAXB) return;
      frame_points++;
      found = 0; best = 0; best_d = 0;
      for (int i = 0; i < live; i++) begin
        if (!t_valid[i]) continue;
        d = sqd(px, t_pos[i][0]) + sqd(py, t_pos[i][1]);
        if (!found || d < best_d) begin
          found = 1; best = i; best_d = d;
        end
      end
      if (found && best_d + sqd(pz, t_pos[best][2]) <=
          longint'(radius) * longint'(radius)) begin
        t_pos[best][0] = px; t_pos[best][1] = py; t_pos[best][2] = pz;
        t_touched[best] = 1;
        queue_event(ev(EV_MOVED, t_id[best], px, py, pz, 1'b1));
        return;
      end
      if (live >= SLOTS) return;
      t_id[live] = free_id();
      t_pos[live][0] = px; t_pos[live][1] = py; t_pos[live][2] = pz;
      t_touched[live] = 1; t_valid[live] = 1;
      queue_event(ev(EV_ENTERED, t_id[live], px, py, pz, 1'b1));
      live++;
    end else begin
      w = 0;
      for (int i = 0; i < live; i++) begin
        if (!t_valid[i]) continue;
        if (!t_touched[i]) begin
          queue_event(ev(EV_EXITED, t_id[i], t_pos[i][0], t_pos[i][1],
                         t_pos[i][2], 1'b0));
        end else begin
          t_id[w] = t_id[i];
          t_pos[w] = t_pos[i];
          t_valid[w] = 1; t_touched[w] = 0;
          w++;
        end
      end
      for (int i = w; i < SLOTS; i++) begin
        t_valid[i] = 0; t_touched[i] = 0;
      end
      live = w;
      frame_points = 0;
      queue_event(ev(EV_DONE, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    end
  endtask

  // receiver: random stall, compare each accepted word
  always @(posedge clk) begin
    event_word_t got, want;
    cycles <= cycles + 1;
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle);
    if (rst_n && out_valid && !out_stall) begin
      got = ev(out_event_kind, out_blob_id, out_x, out_y, out_z, out_last);
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
        // typed rows are checked against the table as well
        if (typed_pending.size() > 0) begin
          if (typed_pending.pop_front() && got !== typed_want[0]) begin
            $display("%0t: table mismatch expected %h actual %h", $time, typed_want[0], got);
            errors++;
          end
          void'(typed_want.pop_front());
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays up after acceptance when the next word follows at once
  task automatic send_word(logic cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd; in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_word(cmd, x, y, z);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() > 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic set_radius(logic [15:0] r);
    drain();
    cfg_we <= 1'b1; cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius = r;
  endtask

  function automatic logic [15:0] near(logic [15:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // one well-formed frame: revisit stored blobs, add fresh ones, maybe overflow
  task automatic random_frame(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if (live > 0 && $urandom_range(99) < 60) begin
        k = $urandom_range(live - 1);
        send_word(CMD_POINT, near(t_pos[k][0], 3000), near(t_pos[k][1], 3000),
                  near(t_pos[k][2], 3000));
      end else begin
        send_word(CMD_POINT, 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    send_word(CMD_EOF, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  row_t table_rows[$];

  task automatic add_row(logic c, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                         bit t, event_word_t w);
    row_t r;
    r.cmd = c; r.x = x; r.y = y; r.z = z; r.typed = t; r.want = w;
    table_rows.insert(table_rows.size(), r);
  endtask

  initial begin
    event_word_t none;
    int before_count;
    none = '0;
    radius = 16'd13107;
    live = 0; frame_points = 0;
    for (int i = 0; i < SLOTS; i++) begin
      t_valid[i] = 0; t_touched[i] = 0; t_id[i] = '0; t_pos[i] = '{default: '0};
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame right after reset gives only the done word
    add_row(CMD_EOF, 16'hffff, 16'hffff, 16'hffff, 1'b1,
            ev(EV_DONE, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    add_row(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
            ev(EV_ENTERED, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    add_row(CMD_POINT, 16'hffff, 16'hffff, 16'hffff, 1'b1,
            ev(EV_ENTERED, 4'd1, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    // moved, and a blob created this frame matched again
    add_row(CMD_POINT, 16'h0010, 16'h0020, 16'h0030, 1'b0, none);
    add_row(CMD_POINT, 16'hfff0, 16'hffff, 16'h0000, 1'b0, none);
    // near the middle: no exact tie, the blob near the origin is nearest but out of range
    add_row(CMD_POINT, 16'h8000, 16'h8000, 16'h8000, 1'b0, none);
    add_row(CMD_EOF, 16'h0000, 16'h0000, 16'h0000, 1'b0, none);
    // untouched blobs exit
    add_row(CMD_EOF, 16'h1234, 16'h5678, 16'h9abc, 1'b0, none);
    foreach (table_rows[i]) begin
      typed_pending.insert(typed_pending.size(), table_rows[i].typed);
      typed_want.insert(typed_want.size(), table_rows[i].want);
      before_count = queued_total;
      send_word(table_rows[i].cmd, table_rows[i].x, table_rows[i].y, table_rows[i].z);
      // rows yielding several words: only the first one carries the table check
      for (int j = before_count + 1; j < queued_total; j++) begin
        typed_pending.insert(typed_pending.size(), 1'b0);
        typed_want.insert(typed_want.size(), none);
      end
    end
    drain();
    typed_pending.delete(); typed_want.delete();

    // too many points in one frame, huge radius so after the first most points collapse into moves
    set_radius(16'hffff);
    random_frame(MAXB + 4);
    // zero radius: every point within the frame limit enters, ids run out and wrap to zero
    set_radius(16'h0000);
    random_frame(MAXB + 2);
    random_frame(MAXB);
    // pause until everything is out
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle = 87; recv_idle = 9; end
      if (phase == 2) begin send_idle = 0; recv_idle = 0; end
      case (phase)
        0: set_radius(16'd13107);
        1: set_radius(16'($urandom_range(20000, 2000)));
        default: set_radius(16'd40000);
      endcase
      for (int f = 0; f < 9; f++) begin
        random_frame($urandom_range(100) < 15 ? MAXB + 3 : int'($urandom_range(1, 12)));
        if ($urandom_range(99) < 10)
          send_word(CMD_EOF, 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
